// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== src/bsr_pkg.sv =====
package bsr_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned ROOT_W      = 32;
    localparam int unsigned STEPS_W     = 6;
    localparam int unsigned EPS_W       = 32;
    localparam int unsigned INDEX_W     = 1;
    localparam int unsigned OUT_TDATA_W = 40;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_EPSILON    = 1'b0;
    localparam logic [INDEX_W-1:0] REG_ITER_LIMIT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [EPS_W-1:0]   EPSILON_RESET    = 32'd6554;
    localparam logic [STEPS_W-1:0] ITER_LIMIT_RESET = 6'd48;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_EVAL,
        S_DONE
    } seq_state_t;

    // Settings seen by the sequencer.
    typedef struct packed {
        logic [EPS_W-1:0]   epsilon;
        logic [STEPS_W-1:0] iteration_limit;
    } cfg_t;

    // One finished result item.
    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic               converged;
        logic [STEPS_W-1:0] steps_used;
    } result_t;

endpackage

// ===== src/bsr_square.sv =====
module bsr_square #(
    parameter int XW = 32
) (
    input  logic            clk,
    input  logic [XW-1:0]   x,
    output logic [2*XW-1:0] sq
);

    logic [2*XW-1:0] sq_reg;

    // Registered squaring unit, shared by every midpoint and the endpoint test.
    always_ff @(posedge clk)
    begin
        sq_reg <= x * x;
    end

    assign sq = sq_reg;

endmodule

// ===== src/bsr_seq.sv =====
`include "assert_macros.svh"

module bsr_seq #(
    parameter int FRAC_BITS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [VALUE_BITS-1:0]   in_value,
    input  bsr_pkg::cfg_t           cfg,
    output logic                    res_valid,
    input  logic                    res_ready,
    output bsr_pkg::result_t        res
);

    // Working widths: operand, square, scaled value, scaled tolerance, compare.
    localparam int XW   = (VALUE_BITS > FRAC_BITS) ? VALUE_BITS : FRAC_BITS + 1;
    localparam int SW   = 2 * XW;
    localparam int TW   = VALUE_BITS + FRAC_BITS;
    localparam int TOLW = bsr_pkg::EPS_W + FRAC_BITS;
    localparam int MW1  = (SW > TW) ? SW : TW;
    localparam int BW   = ((MW1 > TOLW) ? MW1 : TOLW) + 1;

    localparam logic [XW-1:0] ONE_FIX = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;

    bsr_pkg::seq_state_t state_reg, state_next;

    logic [XW-1:0]                 x_reg, x_next;
    logic [XW-1:0]                 lo_reg, lo_next;
    logic [XW-1:0]                 hi_reg, hi_next;
    logic [TW-1:0]                 target_reg, target_next;
    logic [BW-1:0]                 hib_reg, hib_next;
    logic [BW-1:0]                 lob_reg, lob_next;
    logic                          lob_any_reg, lob_any_next;
    logic [bsr_pkg::STEPS_W-1:0]   steps_reg, steps_next;
    logic                          conv_reg, conv_next;
    logic                          endpoint_reg, endpoint_next;
    logic                          zero_reg, zero_next;

    logic [XW-1:0]   in_wide;
    logic [XW-1:0]   hi_start;
    logic [TOLW-1:0] tol;
    logic [SW-1:0]   sq;
    logic [BW-1:0]   sq_ext;
    logic [BW-1:0]   target_ext;
    logic            sq_lt;
    logic            sq_eq;
    logic            in_band;
    logic [XW-1:0]   add_a;
    logic [XW-1:0]   add_b;
    logic [XW:0]     sum;
    logic [XW-1:0]   mid;

    // Squaring unit: the square of x_reg is registered in S_MUL and ready in S_EVAL.
    bsr_square #(
        .XW (XW)
    ) u_square (
        .clk (clk),
        .x   (x_reg),
        .sq  (sq)
    );

    // Start of the interval and tolerance scaled to the square's fraction bits.
    assign in_wide  = XW'(in_value);
    assign hi_start = (in_wide > ONE_FIX) ? in_wide : ONE_FIX;
    assign tol      = {cfg.epsilon, {FRAC_BITS{1'b0}}};

    // Compares of the square against the scaled value and its tolerance band.
    assign sq_ext     = BW'(sq);
    assign target_ext = BW'(target_reg);
    assign sq_lt      = sq_ext < target_ext;
    assign sq_eq      = sq_ext == target_ext;
    assign in_band    = (sq_ext <= hib_reg) && (lob_any_reg || (sq_ext >= lob_reg));

    // Midpoint adder, fed with the interval that the current step leaves.
    assign add_a = (!endpoint_reg && sq_lt) ? x_reg : lo_reg;
    assign add_b = (!endpoint_reg && !sq_lt) ? x_reg : hi_reg;
    assign sum   = (XW+1)'(add_a) + (XW+1)'(add_b);
    assign mid   = sum[XW:1];

    // Sequencer: next state and next values of the working registers.
    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        target_next   = target_reg;
        hib_next      = hib_reg;
        lob_next      = lob_reg;
        lob_any_next  = lob_any_reg;
        steps_next    = steps_reg;
        conv_next     = conv_reg;
        endpoint_next = endpoint_reg;
        zero_next     = zero_reg;
        case (state_reg)
            bsr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    target_next   = {in_value, {FRAC_BITS{1'b0}}};
                    lo_next       = '0;
                    hi_next       = hi_start;
                    x_next        = hi_start;
                    steps_next    = '0;
                    endpoint_next = 1'b1;
                    zero_next     = (in_value == '0);
                    state_next    = bsr_pkg::S_PREP;
                end
            end
            bsr_pkg::S_PREP:
            begin
                hib_next     = target_ext + BW'(tol);
                lob_next     = target_ext - BW'(tol);
                lob_any_next = BW'(tol) > target_ext;
                if (zero_reg)
                begin
                    // The low endpoint is exact.
                    x_next     = '0;
                    conv_next  = 1'b1;
                    state_next = bsr_pkg::S_DONE;
                end
                else
                begin
                    state_next = bsr_pkg::S_MUL;
                end
            end
            bsr_pkg::S_MUL:
            begin
                state_next = bsr_pkg::S_EVAL;
            end
            bsr_pkg::S_EVAL:
            begin
                if (endpoint_reg)
                begin
                    if (sq_eq)
                    begin
                        conv_next  = 1'b1;
                        state_next = bsr_pkg::S_DONE;
                    end
                    else
                    begin
                        x_next        = mid;
                        endpoint_next = 1'b0;
                        state_next    = bsr_pkg::S_MUL;
                    end
                end
                else if (in_band)
                begin
                    conv_next  = 1'b1;
                    state_next = bsr_pkg::S_DONE;
                end
                else if (steps_reg >= cfg.iteration_limit)
                begin
                    conv_next  = 1'b0;
                    state_next = bsr_pkg::S_DONE;
                end
                else
                begin
                    if (sq_lt)
                    begin
                        lo_next = x_reg;
                    end
                    else
                    begin
                        hi_next = x_reg;
                    end
                    x_next     = mid;
                    steps_next = steps_reg + 1'b1;
                    state_next = bsr_pkg::S_MUL;
                end
            end
            bsr_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = bsr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bsr_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bsr_pkg::S_IDLE;
            steps_reg    <= '0;
            conv_reg     <= 1'b0;
            endpoint_reg <= 1'b0;
            zero_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            steps_reg    <= steps_next;
            conv_reg     <= conv_next;
            endpoint_reg <= endpoint_next;
            zero_reg     <= zero_next;
        end
    end

    // Interval and bound registers.
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        target_reg  <= target_next;
        hib_reg     <= hib_next;
        lob_reg     <= lob_next;
        lob_any_reg <= lob_any_next;
    end

    // Handshakes and the result item.
    assign in_ready       = (state_reg == bsr_pkg::S_IDLE);
    assign res_valid      = (state_reg == bsr_pkg::S_DONE);
    assign res.root       = (bsr_pkg::ROOT_W)'(x_reg);
    assign res.converged  = conv_reg;
    assign res.steps_used = steps_reg;

    // The midpoint always lies inside the interval being searched.
    `ASSERT_PROP(a_interval_order, clk, rst_n, (state_reg == bsr_pkg::S_MUL || state_reg == bsr_pkg::S_EVAL) |-> (lo_reg <= x_reg && x_reg <= hi_reg))

    // The step count only ever grows by one or restarts at zero.
    `ASSERT_PROP(a_steps_count, clk, rst_n, (steps_reg != $past(steps_reg)) |-> (steps_reg == $past(steps_reg) + 1'b1 || steps_reg == '0))

    // Giving up is only possible once the endpoint test has been passed.
    `ASSERT_NEVER(a_endpoint_no_giveup, clk, rst_n, state_reg == bsr_pkg::S_DONE && !conv_reg && endpoint_reg)

endmodule

// ===== src/bisection_square_root.sv =====
// Square root of an unsigned fixed-point value by bisection on [0, max(1.0, value)].
// One item is worked on at a time, and s_tready stays low until its result has
// moved into the output register. Every squaring goes through one registered
// multiplier of max(VALUE_BITS, FRAC_BITS+1) bits square; each trial squares in
// S_MUL, then compares and forms the new midpoint in S_EVAL. A zero value goes
// from set-up straight to the result, and a value of exactly 1.0 ends after the
// high-endpoint test; otherwise an item passes the set-up step (S_PREP), the
// high-endpoint test, one trial per midpoint and the handover of the result.
// steps_used does not exceed the iteration limit, 48 after reset. The input
// register is free again as soon as the result sits in the output register,
// even if m_tready is low.
module bisection_square_root #(
    parameter int FRAC_BITS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bsr_pkg::VALUE_W-1:0]       s_tdata,   // [31:0] value
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bsr_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [31:0] root, [37:32] steps_used
    output logic                              m_tuser,   // [0] converged
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsr_pkg::INDEX_W-1:0]       cfg_index,
    input  logic [bsr_pkg::EPS_W-1:0]         cfg_data
);

    logic [bsr_pkg::EPS_W-1:0]   epsilon_reg;
    logic [bsr_pkg::STEPS_W-1:0] iter_limit_reg;
    bsr_pkg::cfg_t               cfg;

    logic             res_valid;
    logic             res_ready;
    bsr_pkg::result_t res;

    logic             out_valid_reg;
    bsr_pkg::result_t out_res_reg;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg    <= bsr_pkg::EPSILON_RESET;
            iter_limit_reg <= bsr_pkg::ITER_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bsr_pkg::REG_EPSILON:
                begin
                    epsilon_reg <= cfg_data;
                end
                bsr_pkg::REG_ITER_LIMIT:
                begin
                    iter_limit_reg <= cfg_data[bsr_pkg::STEPS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.epsilon         = epsilon_reg;
    assign cfg.iteration_limit = iter_limit_reg;

    // Bisection sequencer with its squaring unit.
    bsr_seq #(
        .FRAC_BITS  (FRAC_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_BITS-1:0]),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    // Output stream packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bsr_pkg::OUT_TDATA_W - bsr_pkg::ROOT_W - bsr_pkg::STEPS_W){1'b0}},
                       out_res_reg.steps_used, out_res_reg.root};
    assign m_tuser  = out_res_reg.converged;

endmodule

// ===== bench/tb_top.sv =====
// Scoreboard for the bisection square root: it keeps its own copy of the two
// settings and a queue of the results that are still to arrive.
class root_scoreboard;
    logic [bsr_pkg::EPS_W-1:0]   epsilon;
    logic [bsr_pkg::STEPS_W-1:0] iteration_limit;
    bsr_pkg::result_t            roots_due[$];
    int unsigned                 errors;

    function new();
        epsilon         = bsr_pkg::EPSILON_RESET;
        iteration_limit = bsr_pkg::ITER_LIMIT_RESET;
        errors          = 0;
    endfunction

    // Follow a register write seen on the configuration channel.
    function void set_register(logic [bsr_pkg::INDEX_W-1:0] index,
                               logic [bsr_pkg::EPS_W-1:0] data);
        if (index == bsr_pkg::REG_EPSILON)
            epsilon = data;
        else
            iteration_limit = data[bsr_pkg::STEPS_W-1:0];
    endfunction

    // Bisection on [0, max(1.0, value)] with exact products at 32 fraction bits.
    function bsr_pkg::result_t bisect_root(logic [bsr_pkg::VALUE_W-1:0] value);
        logic [63:0]      target;
        logic [63:0]      tol;
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [63:0]      mid;
        logic [63:0]      sq;
        logic [63:0]      gap;
        int unsigned      steps;
        logic             conv;
        bsr_pkg::result_t res;
        target = {32'd0, value} << 16;
        tol    = {32'd0, epsilon} << 16;
        lo     = '0;
        hi     = (value > 32'h0001_0000) ? {32'd0, value} : 64'h0001_0000;
        steps  = 0;
        conv   = 1'b1;
        if (target == 64'd0)
        begin
            // The low end is exact for a zero value.
            mid = lo;
        end
        else if (hi * hi == target)
        begin
            // The high end is exact, which only happens for 1.0.
            mid = hi;
        end
        else
        begin
            mid = (lo + hi) >> 1;
            forever
            begin
                sq  = mid * mid;
                gap = (sq >= target) ? sq - target : target - sq;
                if (gap <= tol)
                    break;
                if (steps >= iteration_limit)
                begin
                    conv = 1'b0;
                    break;
                end
                if (sq < target)
                    lo = mid;
                else
                    hi = mid;
                mid = (lo + hi) >> 1;
                steps++;
            end
        end
        res.root       = mid[31:0];
        res.converged  = conv;
        res.steps_used = steps[bsr_pkg::STEPS_W-1:0];
        return res;
    endfunction

    function void note_input(logic [bsr_pkg::VALUE_W-1:0] value);
        roots_due.push_back(bisect_root(value));
    endfunction

    function void check_result(logic [bsr_pkg::ROOT_W-1:0] root, logic converged,
                               logic [bsr_pkg::STEPS_W-1:0] steps_used);
        bsr_pkg::result_t want;
        if (roots_due.size() == 0)
        begin
            $error("root: no result outstanding, got %h", root);
            errors++;
            return;
        end
        want = roots_due.pop_front();
        if (root !== want.root)
        begin
            $error("root: expected %h, got %h", want.root, root);
            errors++;
        end
        if (converged !== want.converged)
        begin
            $error("converged: expected %b, got %b", want.converged, converged);
            errors++;
        end
        if (steps_used !== want.steps_used)
        begin
            $error("steps_used: expected %0d, got %0d", want.steps_used, steps_used);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return roots_due.size();
    endfunction
endclass

module tb_top;
    localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned ITEMS_PER_PHASE = 100;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [bsr_pkg::VALUE_W-1:0]       s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [bsr_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic                              m_tuser;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [bsr_pkg::INDEX_W-1:0]       cfg_index;
    logic [bsr_pkg::EPS_W-1:0]         cfg_data;

    root_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    bit          hold_req       = 1'b0;

    bisection_square_root i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit in case the block hangs.
    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watch all three channels at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[bsr_pkg::ROOT_W-1:0], m_tuser,
                                m_tdata[bsr_pkg::ROOT_W +: bsr_pkg::STEPS_W]);
        end
    end

    // Offer one item, idling first at random; valid stays high afterwards.
    task automatic send_value(input logic [bsr_pkg::VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stop offering and wait until every outstanding root has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        @(posedge clk);
    endtask

    // Write both registers; the unused upper bits of the limit word are random.
    task automatic write_settings(input logic [bsr_pkg::EPS_W-1:0] eps,
                                  input logic [bsr_pkg::STEPS_W-1:0] lim);
        logic [25:0] filler;
        filler = 26'($urandom());
        cfg_valid <= 1'b1;
        cfg_index <= bsr_pkg::REG_EPSILON;
        cfg_data  <= eps;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= bsr_pkg::REG_ITER_LIMIT;
        cfg_data  <= {filler, lim};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Ask the receiver to hold off; the request is raised away from the edge.
    task automatic request_hold();
        s_tvalid <= 1'b0;
        @(negedge clk);
        hold_req = 1'b1;
        @(posedge clk);
    endtask

    // Random radicands: small ones, perfect squares and their neighbours,
    // values with few significant bits and fully random words.
    function automatic logic [bsr_pkg::VALUE_W-1:0] pick_value();
        logic [31:0] base;
        base = {16'd0, 16'($urandom())};
        case ($urandom_range(9))
            0, 1:    return $urandom_range(32'h0001_0000);
            2, 3:    return base * base;
            4:       return base * base + $urandom_range(2) - 1;
            5:       return $urandom() >> $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [31:0] under_reset[12];
        logic [31:0] eps_word;
        logic [5:0]  lim;

        under_reset = '{
            32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001,
            32'h0001_0001, 32'h0000_FFFF, 32'h0004_0000, 32'h8000_0000,
            32'hFFFE_0001, 32'h0000_0002, 32'h5555_5555, 32'hAAAA_AAAA
        };
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= bsr_pkg::REG_EPSILON;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, exact endpoints and perfect squares under the reset settings.
        foreach (under_reset[i])
            send_value(under_reset[i]);

        // A zero limit returns the first midpoint.
        drain_results();
        write_settings(32'd0, 6'd0);
        send_value(32'h0002_0000);
        send_value(32'h0001_0000);
        send_value(32'h0000_0000);

        // No tolerance and the largest limit: the interval stalls.
        drain_results();
        write_settings(32'd0, 6'd63);
        send_value(32'h0003_0000);
        send_value(32'hFFFF_FFFF);

        // Widest tolerance and a limit of one: a large value still gives up.
        drain_results();
        write_settings(32'hFFFF_FFFF, 6'd1);
        send_value(32'h1234_5678);
        send_value(32'hFFFF_FFFF);

        // One step and no tolerance: the limit is reached.
        drain_results();
        write_settings(32'd0, 6'd1);
        send_value(32'h0002_0000);

        // Random phases, each with its own settings and one of four idling patterns.
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    eps_word = $urandom_range(32'h0010_0000);
                    lim      = 6'($urandom_range(63, 1));
                end
                1:
                begin
                    eps_word = 32'd0;
                    lim      = 6'd63;
                end
                2:
                begin
                    eps_word = 32'hFFFF_FFFF;
                    lim      = 6'd1;
                end
                3:
                begin
                    eps_word = bsr_pkg::EPSILON_RESET;
                    lim      = bsr_pkg::ITER_LIMIT_RESET;
                end
                4:
                begin
                    eps_word = 32'd0;
                    lim      = 6'd1;
                end
                5:
                begin
                    eps_word = $urandom();
                    lim      = 6'($urandom_range(63, 1));
                end
                6:
                begin
                    eps_word = $urandom_range(32'h0000_FFFF);
                    lim      = 6'd63;
                end
                default:
                begin
                    eps_word = 32'd1;
                    lim      = 6'($urandom_range(20, 1));
                end
            endcase
            write_settings(eps_word, lim);

            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 53;
                end
                default:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Back pressure with the sender still offering items.
                if (phase == 0 && n == 40)
                    request_hold();
                // The sender waits for the block to empty completely.
                if (phase == 5 && n == 50)
                    drain_results();
                send_value(pick_value());
            end
        end

        drain_results();
        repeat (150) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $error("root: %0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
